// ----- sv/hvc_pkg.sv -----
// shared types, constants and helper functions for the hmm viterbi window classifier
// no dependencies; imported by every module of the block
package hvc_pkg;

  // block configuration
  localparam int WINDOW   = 10;
  localparam int ROW_BITS = 12;
  localparam int LOG_BITS = 16;

  // port widths fixed by the item fields
  localparam int ROW_W = 12;
  localparam int CNT_W = 4;
  localparam int SYM_W = 2;

  // configuration register widths
  localparam int CFG_W     = 64;
  localparam int TRANS_W   = 64;
  localparam int EMIS_W    = 48;
  localparam int INIT_W    = 32;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIS0 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIS1 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT  = 2'd3;

  // movement symbol codes
  localparam logic [SYM_W-1:0] SYM_DOWN   = 2'd0;
  localparam logic [SYM_W-1:0] SYM_UP     = 2'd1;
  localparam logic [SYM_W-1:0] SYM_STEADY = 2'd2;

  // row difference within this band counts as steady
  localparam int STEADY_LIM = 2;
  localparam int DIFF_W     = ROW_BITS + 1;
  typedef logic signed [DIFF_W-1:0] diff_t;

  // fill counter and step counters
  localparam int FILL_W   = $clog2(WINDOW + 1);
  localparam int STEP_W   = $clog2(WINDOW);
  localparam int BP_DEPTH = WINDOW - 1;

  // path metric holds 2*WINDOW summed log terms without overflow
  localparam int MET_W = LOG_BITS + $clog2(2 * WINDOW) + 1;
  typedef logic signed [MET_W-1:0] metric_t;

  // front to back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic             full;
    logic [SYM_W-1:0] sym;
  } item_t;

  typedef struct packed {
    logic [TRANS_W-1:0] trans;
    logic [EMIS_W-1:0]  emis0;
    logic [EMIS_W-1:0]  emis1;
    logic [INIT_W-1:0]  init;
  } cfg_t;

  // packed log field k of a register; bits past the register read as zero
  function automatic logic [LOG_BITS-1:0] log_field(input logic [CFG_W-1:0] r,
                                                    input int unsigned k);
    logic [CFG_W+4*LOG_BITS-1:0] e;
    e = {{(4*LOG_BITS){1'b0}}, r};
    return e[k*LOG_BITS +: LOG_BITS];
  endfunction

  // sign extend a log field to metric width
  function automatic metric_t sext(input logic [LOG_BITS-1:0] f);
    return {{(MET_W-LOG_BITS){f[LOG_BITS-1]}}, f};
  endfunction

  // emission log term of one state for a symbol
  function automatic metric_t emis_term(input logic [EMIS_W-1:0] r,
                                        input logic [SYM_W-1:0] sym);
    logic [LOG_BITS-1:0] f;
    case (sym)
      SYM_DOWN:   f = log_field(CFG_W'(r), 0);
      SYM_UP:     f = log_field(CFG_W'(r), 1);
      SYM_STEADY: f = log_field(CFG_W'(r), 2);
      default:    f = log_field(CFG_W'(r), 3);
    endcase
    return sext(f);
  endfunction

endpackage

// ----- sv/hvc_front.sv -----
// front end: turns row positions into movement symbols and tracks window fill
// depends on hvc_pkg
module hvc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [hvc_pkg::ROW_W-1:0] in_row_position,
  output logic                    push,
  output hvc_pkg::item_t          push_item,
  input  logic                    push_ready
);
  import hvc_pkg::*;

  logic [ROW_BITS-1:0] prev_row_r;
  logic [FILL_W-1:0]   fill_cnt_r;
  logic [ROW_BITS-1:0] row;
  logic [ROW_BITS+ROW_W-1:0] row_ext;
  diff_t               diff;
  logic [SYM_W-1:0]    sym;
  logic                full;

  // only the low row bits take part
  assign row_ext = {{ROW_BITS{1'b0}}, in_row_position};
  assign row     = row_ext[ROW_BITS-1:0];
  assign diff    = diff_t'({1'b0, row}) - diff_t'({1'b0, prev_row_r});

  // classify the movement
  always_comb begin
    if (diff > diff_t'(STEADY_LIM)) begin
      sym = SYM_UP;
    end else if (diff < -diff_t'(STEADY_LIM)) begin
      sym = SYM_DOWN;
    end else begin
      sym = SYM_STEADY;
    end
  end

  assign full           = (fill_cnt_r == FILL_W'(WINDOW));
  assign in_ready       = push_ready;
  assign push           = in_valid && push_ready;
  assign push_item.sym  = sym;
  assign push_item.full = full;

  // previous row advances on each transfer; the fill counter advances until it reaches WINDOW
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_row_r <= '0;
      fill_cnt_r <= '0;
    end else if (push) begin
      prev_row_r <= row;
      if (!full) begin
        fill_cnt_r <= fill_cnt_r + FILL_W'(1);
      end
    end
  end

endmodule

// ----- sv/hvc_queue.sv -----
// small fifo of classified items between front and back
// depends on hvc_pkg
module hvc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hvc_pkg::item_t push_item,
  output logic           push_ready,
  input  logic           pop,
  output hvc_pkg::item_t pop_item,
  output logic           pop_valid
);
  import hvc_pkg::*;

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + Q_CNT_W'(1);
        2'b01:   count_r <= count_r - Q_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- sv/hvc_back.sv -----
// back end: symbol window, viterbi forward pass, traceback and result register
// depends on hvc_pkg
module hvc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hvc_pkg::cfg_t            cfg,
  input  logic                     pop_valid,
  input  hvc_pkg::item_t           pop_item,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [hvc_pkg::CNT_W-1:0] out_state0_count,
  output logic                     out_window_full,
  output logic [hvc_pkg::SYM_W-1:0] out_movement_symbol
);
  import hvc_pkg::*;

  typedef enum logic [4:0] {
    BK_IDLE  = 5'b00001,
    BK_FWD   = 5'b00010,
    BK_PICK  = 5'b00100,
    BK_TRACE = 5'b01000,
    BK_DONE  = 5'b10000
  } bk_state_t;

  bk_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SYM_W-1:0] win_r [WINDOW];
  logic [1:0]       bp_r [BP_DEPTH];
  metric_t          v0_r, v1_r, v0_nxt, v1_nxt;
  logic             st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SYM_W-1:0] cur_sym_r;

  logic             out_valid_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_full_r;
  logic [SYM_W-1:0] out_sym_r;

  logic    out_free;
  logic    last_step;
  logic    load_direct;
  logic    load_done;
  metric_t e0, e1;
  metric_t a00, a10, a01, a11;
  logic    arg0, arg1;

  assign out_free  = !out_valid_r || out_ready;
  assign last_step = (step_r == STEP_W'(WINDOW - 1));

  // take an item when idle; a fill item needs the result register free
  assign pop = (state_r == BK_IDLE) && pop_valid && (pop_item.full || out_free);
  assign load_direct = pop && !pop_item.full;
  assign load_done   = (state_r == BK_DONE) && out_free;

  // add-compare-select for both states on the oldest window tap
  assign e0   = emis_term(cfg.emis0, win_r[0]);
  assign e1   = emis_term(cfg.emis1, win_r[0]);
  assign a00  = v0_r + sext(log_field(cfg.trans, 0));
  assign a01  = v0_r + sext(log_field(cfg.trans, 1));
  assign a10  = v1_r + sext(log_field(cfg.trans, 2));
  assign a11  = v1_r + sext(log_field(cfg.trans, 3));
  assign arg0 = (a00 < a10);
  assign arg1 = (a01 < a11);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    v0_nxt    = v0_r;
    v1_nxt    = v1_r;
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      BK_IDLE: begin
        if (pop && pop_item.full) begin
          state_nxt = BK_FWD;
          step_nxt  = '0;
        end
      end
      BK_FWD: begin
        if (step_r == '0) begin
          v0_nxt = sext(log_field(CFG_W'(cfg.init), 0)) + e0;
          v1_nxt = sext(log_field(CFG_W'(cfg.init), 1)) + e1;
        end else begin
          v0_nxt = (arg0 ? a10 : a00) + e0;
          v1_nxt = (arg1 ? a11 : a01) + e1;
        end
        if (last_step) begin
          state_nxt = BK_PICK;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      BK_PICK: begin
        // lower state wins a tie
        st_nxt    = (v0_r < v1_r);
        cnt_nxt   = '0;
        step_nxt  = '0;
        state_nxt = BK_TRACE;
      end
      BK_TRACE: begin
        if (!st_r) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        st_nxt = bp_r[0][st_r];
        if (last_step) begin
          state_nxt = BK_DONE;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    v0_r   <= v0_nxt;
    v1_r   <= v1_nxt;
    st_r   <= st_nxt;
    cnt_r  <= cnt_nxt;
    if (pop) begin
      cur_sym_r <= pop_item.sym;
    end
  end

  // symbol window: shift in on a transfer, rotate once per forward step
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WINDOW-1] <= pop_item.sym;
    end else if (state_r == BK_FWD) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WINDOW-1] <= win_r[0];
    end
  end

  // backpointer stack: pushed during forward, popped during traceback
  always_ff @(posedge clk) begin
    if (state_r == BK_FWD && step_r != '0) begin
      for (int i = 1; i < BP_DEPTH; i++) begin
        bp_r[i] <= bp_r[i-1];
      end
      bp_r[0] <= {arg1, arg0};
    end else if (state_r == BK_TRACE) begin
      for (int i = 0; i < BP_DEPTH - 1; i++) begin
        bp_r[i] <= bp_r[i+1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_direct || load_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      out_cnt_r  <= '0;
      out_full_r <= 1'b0;
      out_sym_r  <= pop_item.sym;
    end else if (load_done) begin
      out_cnt_r  <= cnt_r;
      out_full_r <= 1'b1;
      out_sym_r  <= cur_sym_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_state0_count    = out_cnt_r;
  assign out_window_full     = out_full_r;
  assign out_movement_symbol = out_sym_r;

endmodule

// ----- sv/hmm_viterbi_window_classifier.sv -----
// top level of the hmm viterbi window classifier: config registers, front, queue, back
// depends on hvc_pkg, hvc_front, hvc_queue, hvc_back
//
// Usage:
//   Input channel (in_valid/in_ready, in_row_position) takes one frame position
//   per transfer. Result channel (out_valid/out_ready) returns one result per
//   input, in order: the movement symbol, a window-full flag and the count of
//   window positions decoded as state 0.
//   The first WINDOW inputs only fill the symbol window and come back through
//   the queue with window_full low and a zero count. Every later input runs a
//   full viterbi pass: WINDOW forward steps, one end-state pick and WINDOW
//   traceback steps on one add-compare-select unit, before its result is
//   loaded. One decode runs at a time, so the back end takes no new item until
//   the last result has been loaded into the output register.
//   A two-entry queue behind the front keeps input transfers going while the
//   back end decodes or while a result waits on out_ready; a stalled result
//   holds in the output register and the back end waits behind it.
//   Configuration (cfg_we, cfg_index, cfg_wdata) writes one register per cycle;
//   the user must write it only while the block is idle; the block does not enforce this.
//   Reset (rst_n, synchronous) clears the registers to zero, the previous row
//   and the fill count; the window contents are rebuilt by the next inputs.
module hmm_viterbi_window_classifier (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hvc_pkg::ROW_W-1:0]     in_row_position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hvc_pkg::CNT_W-1:0]     out_state0_count,
  output logic                         out_window_full,
  output logic [hvc_pkg::SYM_W-1:0]     out_movement_symbol,
  input  logic                         cfg_we,
  input  logic [hvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hvc_pkg::CFG_W-1:0]     cfg_wdata
);
  import hvc_pkg::*;

  cfg_t  cfg_r;
  logic  push;
  item_t push_item;
  logic  push_ready;
  logic  pop;
  item_t pop_item;
  logic  pop_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRANS: cfg_r.trans <= cfg_wdata[TRANS_W-1:0];
        CFG_EMIS0: cfg_r.emis0 <= cfg_wdata[EMIS_W-1:0];
        CFG_EMIS1: cfg_r.emis1 <= cfg_wdata[EMIS_W-1:0];
        CFG_INIT:  cfg_r.init  <= cfg_wdata[INIT_W-1:0];
        default:   cfg_r       <= cfg_r;
      endcase
    end
  end

  hvc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_row_position (in_row_position),
    .push            (push),
    .push_item       (push_item),
    .push_ready      (push_ready)
  );

  hvc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid)
  );

  hvc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .pop_valid           (pop_valid),
    .pop_item            (pop_item),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_state0_count    (out_state0_count),
    .out_window_full     (out_window_full),
    .out_movement_symbol (out_movement_symbol)
  );

`ifndef ASSERT_OFF
  // back end only takes from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("pop from empty queue");

  // a result from the fill phase carries no decode count
  a_fill_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_window_full |-> out_state0_count == '0)
    else $error("nonzero count before window full");

  // reported symbol is always a legal code
  a_sym_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_movement_symbol == SYM_DOWN) || (out_movement_symbol == SYM_UP) ||
                  (out_movement_symbol == SYM_STEADY))
    else $error("illegal movement symbol");
`endif

endmodule
